FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks are sampled on the rising clock edge and held off while reset is active.
`define CHECK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mhri_pkg.sv
package mhri_pkg;

    localparam int SYNC      = 4;
    localparam int ADDR_BITS = 24;

    localparam int LANE_W  = 8;
    localparam int SLICE_W = 2;
    localparam int OFS_W   = 14;
    localparam int LEN_W   = 15;
    localparam int ADDR_W  = 24;
    localparam int RAND_W  = 32;
    localparam int POS_W   = 24;
    localparam int RAS_W   = 16;
    localparam int SUM_W   = 18;
    localparam int LL_W    = 22;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    localparam int NSTG       = 10;
    localparam int DIV_STEPS  = 6;
    localparam int LMOD_STEPS = 4;

    localparam logic [LEN_W-1:0]   LEN_MIN    = LEN_W'(2);
    localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(16384);
    localparam logic [SLICE_W-1:0] LAST_SLICE = SLICE_W'(SYNC - 1);
    localparam logic [ADDR_W-1:0]  ADDR_MASK  = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic REG_LANE_COUNT = 1'b0;
    localparam logic REG_SEG_LENGTH = 1'b1;

    typedef struct packed {
        logic               first_pass;
        logic [SLICE_W-1:0] slice;
        logic [LANE_W-1:0]  lane;
        logic [OFS_W-1:0]   offset;
        logic [RAND_W-1:0]  prev_word;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  prev_address;
        logic [LANE_W-1:0]  tgt_lane;
        logic [SLICE_W-1:0] tgt_slice;
        logic [OFS_W-1:0]   ref_offset;
        logic [ADDR_W-1:0]  ref_address;
        logic               valid_res;
    } result_t;

    typedef struct packed {
        logic [LANE_W-1:0] lane_count;
        logic [LEN_W-1:0]  seg_length;
    } cfg_t;

    typedef struct packed {
        logic [LEN_W-1:0]   rem;
        logic [SUM_W-1:0]   num;
        logic [SLICE_W-1:0] quo;
    } div_t;

    typedef struct packed {
        logic [LANE_W-1:0] rem;
        logic [LANE_W-1:0] num;
    } lmod_t;

    typedef struct packed {
        logic               inv;
        logic               fp;
        logic [SLICE_W-1:0] sl;
        logic [LANE_W-1:0]  ln;
        logic [OFS_W-1:0]   ix;
        logic [LEN_W-1:0]   len;
        logic [LANE_W-1:0]  lanes;
        logic [ADDR_W-1:0]  prev;
        logic [LANE_W-1:0]  rl;
        logic [RAS_W-1:0]   start;
    } ctx_t;

    function automatic logic [ADDR_W-1:0] slice_mul(logic [SLICE_W-1:0] sel,
                                                    logic [LL_W-1:0] v);
        logic [ADDR_W-1:0] w;
        w = ADDR_W'(v);
        case (sel)
            2'd0:    return '0;
            2'd1:    return w;
            2'd2:    return w << 1;
            2'd3:    return w + (w << 1);
            default: return '0;
        endcase
    endfunction

    function automatic div_t div_step(div_t d, logic [LEN_W-1:0] len);
        logic [LEN_W:0] t;
        div_t r;
        t = {d.rem, d.num[SUM_W-1]};
        r = d;
        r.num = {d.num[SUM_W-2:0], 1'b0};
        if (t >= {1'b0, len}) begin
            r.rem = LEN_W'(t - {1'b0, len});
            r.quo = {d.quo[SLICE_W-2:0], 1'b1};
        end else begin
            r.rem = t[LEN_W-1:0];
            r.quo = {d.quo[SLICE_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic lmod_t lmod_step(lmod_t d, logic [LANE_W-1:0] lanes);
        logic [LANE_W:0] t;
        lmod_t r;
        t = {d.rem, d.num[LANE_W-1]};
        r.num = {d.num[LANE_W-2:0], 1'b0};
        if (t >= {1'b0, lanes}) begin
            r.rem = LANE_W'(t - {1'b0, lanes});
        end else begin
            r.rem = t[LANE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/mhri_cfg.sv
module mhri_cfg
    import mhri_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [LANE_W-1:0] lane_count_reg, lane_count_next;
    logic [LEN_W-1:0]  seg_len_reg, seg_len_next;
    logic              wr;
    logic              idx;

    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[CFG_AW-1];
    assign pready = 1'b1;

    always_comb
    begin
        lane_count_next = lane_count_reg;
        seg_len_next    = seg_len_reg;
        if (wr)
        begin
            case (idx)
                REG_LANE_COUNT: lane_count_next = pwdata[LANE_W-1:0];
                REG_SEG_LENGTH: seg_len_next    = pwdata[LEN_W-1:0];
                default:        lane_count_next = lane_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_count_reg <= LANE_W'(1);
            seg_len_reg    <= LEN_W'(2);
        end
        else
        begin
            lane_count_reg <= lane_count_next;
            seg_len_reg    <= seg_len_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_LANE_COUNT: prdata = CFG_DW'(lane_count_reg);
            REG_SEG_LENGTH: prdata = CFG_DW'(seg_len_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.lane_count = lane_count_reg;
    assign cfg.seg_length = seg_len_reg;

endmodule

FILE: hdl/mhri_lmod_stage.sv
module mhri_lmod_stage
    import mhri_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [LANE_W-1:0] lanes,
    input  lmod_t             d_in,
    output lmod_t             d_out
);

    lmod_t d_reg, d_next;

    always_comb
    begin
        d_next = d_in;
        for (int i = 0; i < LMOD_STEPS; i++)
        begin
            d_next = lmod_step(d_next, lanes);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

FILE: hdl/mhri_div_stage.sv
module mhri_div_stage
    import mhri_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [LEN_W-1:0] len,
    input  div_t             d_in,
    output div_t             d_out
);

    div_t d_reg, d_next;

    always_comb
    begin
        d_next = d_in;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            d_next = div_step(d_next, len);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

FILE: hdl/memory_hard_hash_ref_index.sv
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_stall      item_t
// result    out        result_valid / result_stall  result_t
// config    in         psel penable pwrite pready   paddr, pwdata, prdata
//
// One item enters per cycle while item_stall is low; each result passes through every stage in order.
// The ten stages hold the lane modulo (two stages of four steps), the square and
// the scaling multiply, and the division by the segment length (three stages of six steps).
// A stalled result holds the last stage and the full stages directly before it; empty stages further up keep filling.
// Reset clears the stage valid bits and sets the lane count to 1 and the segment length to 2.
`include "assert_macros.svh"

module memory_hard_hash_ref_index
    import mhri_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    cfg_t              cfg;
    logic [NSTG-1:0]   v_reg;
    logic [NSTG-1:0]   en;
    logic [LL_W-1:0]   ll_reg, ll_next;
    logic [LANE_W-1:0] lanes_c;
    logic [LEN_W-1:0]  len_c;

    item_t             s0_reg;
    ctx_t              c_reg [1:8];
    ctx_t              c1_next, c2_next, c3_next;
    logic [POS_W-1:0]  x1_reg, x2_reg, x3_reg;
    logic [2*POS_W-1:0] sq;
    lmod_t             lm_in, l1, l2;
    logic [RAS_W-1:0]  ras_m1_3_reg, ras_m1_3_next, ras_m1_4_reg, prodhi4_reg;
    logic [RAS_W+POS_W-1:0] prod;
    div_t              d5_reg, d5_next, d6, d7, d8;
    result_t           out_reg, out_next;

    mhri_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || !result_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign item_stall   = !en[0];
    assign result_valid = v_reg[NSTG-1];
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= item_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign lanes_c = (cfg.lane_count == '0) ? LANE_W'(1) : cfg.lane_count;
    assign len_c   = (cfg.seg_length < LEN_MIN) ? LEN_MIN :
                     (cfg.seg_length > LEN_MAX) ? LEN_MAX : cfg.seg_length;
    assign ll_next = LL_W'(lanes_c) * LL_W'(len_c);

    always_ff @(posedge clk)
    begin
        ll_reg <= ll_next;
    end

    // Stage 0: input register.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_reg <= item;
        end
    end

    // Stage 1: context, square of the low word, first half of the lane modulo.
    always_comb
    begin
        c1_next       = '0;
        c1_next.fp    = s0_reg.first_pass;
        c1_next.sl    = s0_reg.slice;
        c1_next.ln    = s0_reg.lane;
        c1_next.ix    = s0_reg.offset;
        c1_next.len   = len_c;
        c1_next.lanes = lanes_c;
        c1_next.inv   = s0_reg.first_pass && (s0_reg.slice == '0) &&
                        (s0_reg.offset < OFS_W'(2));
    end

    assign sq        = s0_reg.prev_word[POS_W-1:0] * s0_reg.prev_word[POS_W-1:0];
    assign lm_in.rem = '0;
    assign lm_in.num = s0_reg.prev_word[RAND_W-1:RAND_W-LANE_W];

    mhri_lmod_stage u_lmod1 (
        .clk   (clk),
        .en    (en[1]),
        .lanes (lanes_c),
        .d_in  (lm_in),
        .d_out (l1)
    );

    // Stage 2: previous block address, second half of the lane modulo.
    always_comb
    begin
        logic [LEN_W-1:0]         idx;
        logic [SLICE_W-1:0]       sel;
        logic [LANE_W+LEN_W-1:0]  lnlen;
        c2_next = c_reg[1];
        if (c_reg[1].ix == '0)
        begin
            idx = c_reg[1].len - LEN_W'(1);
            sel = (c_reg[1].sl == '0) ? LAST_SLICE : c_reg[1].sl - SLICE_W'(1);
        end
        else
        begin
            idx = LEN_W'(c_reg[1].ix) - LEN_W'(1);
            sel = c_reg[1].sl;
        end
        lnlen        = c_reg[1].ln * c_reg[1].len;
        c2_next.prev = (ADDR_W'(idx) + ADDR_W'(lnlen) + slice_mul(sel, ll_reg)) & ADDR_MASK;
    end

    mhri_lmod_stage u_lmod2 (
        .clk   (clk),
        .en    (en[2]),
        .lanes (c_reg[1].lanes),
        .d_in  (l1),
        .d_out (l2)
    );

    // Stage 3: reference lane, size of the reference area and its start.
    always_comb
    begin
        logic              same;
        logic [RAS_W:0]    slen;
        logic [RAS_W:0]    len3;
        logic [RAS_W:0]    ix17;
        logic [RAS_W:0]    iz;
        logic [RAS_W:0]    ras;
        c3_next = c_reg[2];
        same    = (l2.rem == c_reg[2].ln);
        slen    = (RAS_W+1)'(slice_mul(c_reg[2].sl, LL_W'(c_reg[2].len)));
        len3    = (RAS_W+1)'(slice_mul(LAST_SLICE, LL_W'(c_reg[2].len)));
        ix17    = (RAS_W+1)'(c_reg[2].ix);
        iz      = (RAS_W+1)'(c_reg[2].ix == '0);
        c3_next.rl = l2.rem;
        if (c_reg[2].fp)
        begin
            if (c_reg[2].sl == '0)
            begin
                c3_next.rl = c_reg[2].ln;
                ras = ix17 - (RAS_W+1)'(1);
            end
            else if (same)
            begin
                ras = slen + ix17 - (RAS_W+1)'(1);
            end
            else
            begin
                ras = slen - iz;
            end
        end
        else if (same)
        begin
            ras = len3 + ix17 - (RAS_W+1)'(1);
        end
        else
        begin
            ras = len3 - iz;
        end
        if (ras == '0)
        begin
            ras = (RAS_W+1)'(1);
        end
        ras_m1_3_next = RAS_W'(ras - (RAS_W+1)'(1));
        if (c_reg[2].fp || (c_reg[2].sl == LAST_SLICE))
        begin
            c3_next.start = '0;
        end
        else
        begin
            c3_next.start = RAS_W'(slice_mul(c_reg[2].sl + SLICE_W'(1),
                                             LL_W'(c_reg[2].len)));
        end
    end

    // Stage 4: scale the area by the squared word.
    assign prod = ras_m1_3_reg * x3_reg;

    // Stage 5: relative position and dividend.
    always_comb
    begin
        logic [RAS_W-1:0] rel;
        rel         = ras_m1_4_reg - prodhi4_reg;
        d5_next.rem = '0;
        d5_next.quo = '0;
        d5_next.num = SUM_W'(c_reg[4].start) + SUM_W'(rel);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            c_reg[1] <= c1_next;
            x1_reg   <= sq[2*POS_W-1:POS_W];
        end
        if (en[2])
        begin
            c_reg[2] <= c2_next;
            x2_reg   <= x1_reg;
        end
        if (en[3])
        begin
            c_reg[3]     <= c3_next;
            x3_reg       <= x2_reg;
            ras_m1_3_reg <= ras_m1_3_next;
        end
        if (en[4])
        begin
            c_reg[4]     <= c_reg[3];
            ras_m1_4_reg <= ras_m1_3_reg;
            prodhi4_reg  <= prod[RAS_W+POS_W-1:POS_W];
        end
        if (en[5])
        begin
            c_reg[5] <= c_reg[4];
            d5_reg   <= d5_next;
        end
        for (int i = 6; i <= 8; i++)
        begin
            if (en[i])
            begin
                c_reg[i] <= c_reg[i-1];
            end
        end
    end

    // Stages 6 to 8: division of the position by the segment length.
    mhri_div_stage u_div6 (
        .clk   (clk),
        .en    (en[6]),
        .len   (c_reg[5].len),
        .d_in  (d5_reg),
        .d_out (d6)
    );

    mhri_div_stage u_div7 (
        .clk   (clk),
        .en    (en[7]),
        .len   (c_reg[6].len),
        .d_in  (d6),
        .d_out (d7)
    );

    mhri_div_stage u_div8 (
        .clk   (clk),
        .en    (en[8]),
        .len   (c_reg[7].len),
        .d_in  (d7),
        .d_out (d8)
    );

    // Stage 9: reference address and output register.
    always_comb
    begin
        logic [OFS_W-1:0]        ro;
        logic [LANE_W+LEN_W-1:0] rllen;
        ro    = d8.rem[OFS_W-1:0];
        rllen = c_reg[8].rl * c_reg[8].len;
        out_next = '0;
        if (!c_reg[8].inv)
        begin
            out_next.prev_address = c_reg[8].prev;
            out_next.tgt_lane     = c_reg[8].rl;
            out_next.tgt_slice    = d8.quo;
            out_next.ref_offset   = ro;
            out_next.ref_address  = (ADDR_W'(ro) + ADDR_W'(rllen) +
                                     slice_mul(d8.quo, ll_reg)) & ADDR_MASK;
            out_next.valid_res    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG-1])
        begin
            out_reg <= out_next;
        end
    end

    `CHECK_IMPLY(a_stall_full, clk, rst_n, item_stall, &v_reg, "item stalled with a free stage")
    `CHECK_IMPLY(a_invalid_zero, clk, rst_n, result_valid && !result.valid_res, result == '0, "invalid result carries nonzero fields")
    `CHECK_IMPLY(a_rem_range, clk, rst_n, v_reg[8], d8.rem < c_reg[8].len, "division remainder not below segment length")

endmodule

FILE: sim/tb.sv
module tb;
    import mhri_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;
    localparam int PRINT_LIMIT = 40;
    localparam int BLOCK_ITEMS = 34;

    localparam logic [CFG_AW-1:0] LANE_COUNT_ADDR = CFG_AW'(4 * int'(REG_LANE_COUNT));
    localparam logic [CFG_AW-1:0] SEG_LEN_ADDR    = CFG_AW'(4 * int'(REG_SEG_LENGTH));

    typedef struct packed {
        logic [LANE_W-1:0] lanes;
        logic [LEN_W-1:0]  len;
        item_t             stim;
        logic              typed;
        result_t           want;
    } row_t;

    localparam result_t ALL_ZERO = '0;
    localparam int DIR_ROWS = 20;

    localparam row_t DIRECTED [DIR_ROWS] = '{
        {8'd1, 15'd2, {1'b1, 2'd0, 8'd0, 14'd0, 32'hFFFF_FFFF}, 1'b1, ALL_ZERO},
        {8'd1, 15'd2, {1'b1, 2'd0, 8'd254, 14'd1, 32'h0000_0000}, 1'b1, ALL_ZERO},
        {8'd1, 15'd2, {1'b1, 2'd0, 8'd0, 14'd2, 32'h1234_5678}, 1'b1,
            {24'd1, 8'd0, 2'd0, 14'd0, 24'd0, 1'b1}},
        {8'd1, 15'd2, {1'b1, 2'd0, 8'd0, 14'd3, 32'h0000_0000}, 1'b1,
            {24'd2, 8'd0, 2'd0, 14'd1, 24'd1, 1'b1}},
        {8'd1, 15'd2, {1'b0, 2'd0, 8'd0, 14'd0, 32'hFFFF_FFFF}, 1'b0, ALL_ZERO},
        {8'd1, 15'd2, {1'b1, 2'd1, 8'd254, 14'd16383, 32'h0000_0000}, 1'b0, ALL_ZERO},
        {8'd4, 15'd16, {1'b1, 2'd1, 8'd1, 14'd0, 32'h01FF_FFFF}, 1'b0, ALL_ZERO},
        {8'd4, 15'd16, {1'b1, 2'd2, 8'd1, 14'd5, 32'h0280_0000}, 1'b0, ALL_ZERO},
        {8'd4, 15'd16, {1'b0, 2'd3, 8'd3, 14'd15, 32'h0300_0001}, 1'b0, ALL_ZERO},
        {8'd4, 15'd16, {1'b0, 2'd0, 8'd0, 14'd0, 32'hFFFF_FFFF}, 1'b0, ALL_ZERO},
        {8'd4, 15'd16, {1'b0, 2'd2, 8'd2, 14'd0, 32'h0200_0000}, 1'b0, ALL_ZERO},
        {8'd4, 15'd16, {1'b1, 2'd0, 8'd3, 14'd0, 32'h0000_0000}, 1'b1, ALL_ZERO},
        {8'd255, 15'd16384, {1'b0, 2'd3, 8'd254, 14'd16383, 32'hFFFF_FFFF}, 1'b0, ALL_ZERO},
        {8'd255, 15'd16384, {1'b1, 2'd3, 8'd254, 14'd16383, 32'hFEFF_FFFF}, 1'b0, ALL_ZERO},
        {8'd255, 15'd16384, {1'b0, 2'd1, 8'd0, 14'd0, 32'h0000_0000}, 1'b0, ALL_ZERO},
        {8'd255, 15'd16384, {1'b1, 2'd0, 8'd128, 14'd2, 32'h80AB_CDEF}, 1'b0, ALL_ZERO},
        {8'd0, 15'd1, {1'b0, 2'd2, 8'd7, 14'd9, 32'hA5A5_A5A5}, 1'b0, ALL_ZERO},
        {8'd0, 15'd1, {1'b1, 2'd3, 8'd0, 14'd1, 32'h5A5A_5A5A}, 1'b0, ALL_ZERO},
        {8'd3, 15'd32767, {1'b0, 2'd1, 8'd2, 14'd8191, 32'hFFFF_FFFF}, 1'b0, ALL_ZERO},
        {8'd3, 15'd32767, {1'b0, 2'd0, 8'd255, 14'd16383, 32'h7FFF_FFFF}, 1'b0, ALL_ZERO}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    item_t             item;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    logic [LANE_W-1:0] cfg_lanes = 8'd1;
    logic [LEN_W-1:0]  cfg_len = 15'd2;

    result_t expected_refs [$];
    int mismatches = 0;
    int results_checked = 0;
    int configs_written = 0;
    int unfillable_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;

    memory_hard_hash_ref_index u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint unsigned block_addr(longint unsigned ln, longint unsigned sl,
                                                   longint unsigned idx, longint unsigned len,
                                                   longint unsigned lanes);
        return idx + ln * len + sl * len * lanes;
    endfunction

    function automatic result_t predict_ref_index(item_t stim);
        longint unsigned lanes, len, sync_n, sl, ln, ix, pr;
        longint unsigned prev, rl, ras, x, rel, start, pos, ro, rs, ref_abs;
        result_t r;
        r = '0;
        sync_n = 64'(SYNC);
        lanes = (cfg_lanes == '0) ? 64'd1 : 64'(cfg_lanes);
        len = 64'(cfg_len);
        if (len < 2)
            len = 2;
        if (len > 16384)
            len = 16384;
        sl = 64'(stim.slice);
        ln = 64'(stim.lane);
        ix = 64'(stim.offset);
        pr = 64'(stim.prev_word);

        if (stim.first_pass && sl == 0 && ix < 2)
            return r;

        if (ix == 0)
            prev = (sl == 0) ? block_addr(ln, sync_n - 1, len - 1, len, lanes)
                             : block_addr(ln, sl - 1, len - 1, len, lanes);
        else
            prev = block_addr(ln, sl, ix - 1, len, lanes);

        rl = (pr >> 24) % lanes;
        if (stim.first_pass)
        begin
            if (sl == 0)
            begin
                rl = ln;
                ras = ix - 1;
            end
            else if (rl == ln)
                ras = sl * len + ix - 1;
            else
                ras = sl * len - ((ix == 0) ? 1 : 0);
        end
        else
        begin
            if (rl == ln)
                ras = (sync_n - 1) * len + ix - 1;
            else
                ras = (sync_n - 1) * len - ((ix == 0) ? 1 : 0);
        end
        if (ras == 0)
            ras = 1;

        x = pr & 64'hFF_FFFF;
        x = (x * x) >> 24;
        rel = (ras - 1) - (((ras - 1) * x) >> 24);

        if (stim.first_pass)
            start = 0;
        else
            start = (sl == sync_n - 1) ? 0 : (sl + 1) * len;

        pos = (start + rel) % (sync_n * len);
        ro = pos % len;
        rs = pos / len;
        ref_abs = block_addr(rl, rs, ro, len, lanes);

        r.prev_address = ADDR_W'(prev) & ADDR_MASK;
        r.tgt_lane     = LANE_W'(rl);
        r.tgt_slice    = SLICE_W'(rs);
        r.ref_offset   = OFS_W'(ro);
        r.ref_address  = ADDR_W'(ref_abs) & ADDR_MASK;
        r.valid_res    = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < PRINT_LIMIT)
            $display("Mismatch on %s at result %0d: got %0h, wanted %0h",
                     what, results_checked, got, want);
        mismatches++;
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_refs.size() == 0)
        begin
            report_mismatch("unexpected result", 64'(got.prev_address), 64'd0);
            return;
        end
        want = expected_refs.pop_front();
        if (got.prev_address !== want.prev_address)
            report_mismatch("prev_address", 64'(got.prev_address), 64'(want.prev_address));
        if (got.tgt_lane !== want.tgt_lane)
            report_mismatch("tgt_lane", 64'(got.tgt_lane), 64'(want.tgt_lane));
        if (got.tgt_slice !== want.tgt_slice)
            report_mismatch("tgt_slice", 64'(got.tgt_slice), 64'(want.tgt_slice));
        if (got.ref_offset !== want.ref_offset)
            report_mismatch("ref_offset", 64'(got.ref_offset), 64'(want.ref_offset));
        if (got.ref_address !== want.ref_address)
            report_mismatch("ref_address", 64'(got.ref_address), 64'(want.ref_address));
        if (got.valid_res !== want.valid_res)
            report_mismatch("valid_res", 64'(got.valid_res), 64'(want.valid_res));
        results_checked++;
    endtask

    // Each register write is followed directly by a read of the same register.
    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== data)
            report_mismatch("register readback", 64'(prdata), 64'(data));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_config(input logic [LANE_W-1:0] lanes, input logic [LEN_W-1:0] len);
        write_reg(LANE_COUNT_ADDR, CFG_DW'(lanes));
        write_reg(SEG_LEN_ADDR, CFG_DW'(len));
        cfg_lanes = lanes;
        cfg_len = len;
        configs_written++;
    endtask

    task automatic send_item(input item_t stim, input result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= stim;
        do
            @(posedge clk);
        while (item_stall);
        expected_refs.push_back(want);
        if (!want.valid_res)
            unfillable_sent++;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_refs.size() != 0)
            @(posedge clk);
    endtask

    function automatic item_t random_item();
        item_t stim;
        int lanes, len;
        lanes = (cfg_lanes == '0) ? 1 : int'(cfg_lanes);
        len = (cfg_len < 2) ? 2 : ((cfg_len > 16384) ? 16384 : int'(cfg_len));
        stim.first_pass = 1'($urandom_range(1));
        stim.slice      = SLICE_W'($urandom_range(3));
        stim.prev_word  = $urandom;
        if ($urandom_range(9) < 8)
        begin
            stim.lane   = LANE_W'($urandom_range(lanes - 1));
            stim.offset = OFS_W'($urandom_range(len - 1));
            if ($urandom_range(9) == 0)
                stim.offset = OFS_W'($urandom_range(2));
        end
        else
        begin
            stim.lane   = LANE_W'($urandom);
            stim.offset = OFS_W'($urandom);
        end
        if ($urandom_range(3) == 0)
            stim.prev_word[31:24] = stim.lane;
        return stim;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                check_result(result);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        item_t stim;
        logic [LANE_W-1:0] lanes;
        logic [LEN_W-1:0] len;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 82;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED[i].lanes != cfg_lanes || DIRECTED[i].len != cfg_len)
            begin
                drain_results();
                write_config(DIRECTED[i].lanes, DIRECTED[i].len);
            end
            send_item(DIRECTED[i].stim, DIRECTED[i].typed ? DIRECTED[i].want
                                                          : predict_ref_index(DIRECTED[i].stim));
        end

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 13 : ((p == 1) ? 82 : 0);
            recv_idle_pct = (p == 0) ? 82 : ((p == 1) ? 13 : 0);
            for (int b = 0; b < 4; b++)
            begin
                drain_results();
                case (b)
                    0:
                    begin
                        lanes = LANE_W'($urandom_range(1, 4));
                        len   = LEN_W'($urandom_range(2, 8));
                    end
                    1:
                    begin
                        lanes = LANE_W'($urandom_range(1, 16));
                        len   = LEN_W'($urandom_range(2, 300));
                    end
                    2:
                    begin
                        lanes = LANE_W'($urandom_range(1, 255));
                        len   = LEN_W'($urandom_range(2, 16384));
                    end
                    default:
                    begin
                        lanes = ($urandom_range(3) == 0) ? '0 : LANE_W'($urandom_range(255));
                        case ($urandom_range(3))
                            0:       len = '0;
                            1:       len = LEN_W'(1);
                            2:       len = LEN_W'($urandom_range(16385, 32767));
                            default: len = LEN_W'($urandom_range(2, 40));
                        endcase
                    end
                endcase
                write_config(lanes, len);
                if (p == 2 && b == 0)
                    hold_req = 1'b1;
                for (int n = 0; n < BLOCK_ITEMS; n++)
                begin
                    if (p == 2 && b == 1 && n == BLOCK_ITEMS / 2)
                        drain_results();
                    stim = random_item();
                    send_item(stim, predict_ref_index(stim));
                end
            end
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("Checked %0d reference index results over %0d register settings,",
                 results_checked, configs_written);
        $display("%0d of them unfillable blocks, with stalls on both channels.",
                 unfillable_sent);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
